// ===== hw/rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int WORD_WIDTH_DEF  = 32;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 1'b1;

	localparam longint unsigned EXPONENT_RESET = 65537;
	localparam longint unsigned MODULUS_RESET  = 3233;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MUL,
		ST_SQUARE,
		ST_DONE
	} mexp_state_t;

	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_ACC,
		OP_SQUARE
	} mexp_op_t;

	typedef struct packed {
		logic     load_item;
		logic     start_mul;
		mexp_op_t op;
		logic     shift_exp;
		logic     finish;
	} mexp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic mod_zero;
		logic exp_zero;
		logic exp_lsb;
		logic exp_last;
	} mexp_status_t;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// iterative modular multiplier, msb-first add-and-double, one bit per cycle
// ----------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_WIDTH-1:0] addend,
	input  logic [WORD_WIDTH-1:0] scan,
	input  logic [WORD_WIDTH-1:0] modulus,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] product
);

	localparam int CNT_W = $clog2(WORD_WIDTH);
	localparam int EXT_W = WORD_WIDTH + 2;

	logic [WORD_WIDTH-1:0] r_q;
	logic [WORD_WIDTH-1:0] sh_q;
	logic [WORD_WIDTH-1:0] a_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [EXT_W-1:0]      x;
	logic [EXT_W-1:0]      m1;
	logic [EXT_W-1:0]      m2;
	logic [EXT_W-1:0]      x_m1;
	logic [EXT_W-1:0]      x_m2;
	logic [WORD_WIDTH-1:0] r_next;

	// x = 2r (+ a) stays below 3m, so at most two subtractions of m
	always_comb begin
		x    = {1'b0, r_q, 1'b0} + (sh_q[WORD_WIDTH-1] ? {2'b00, a_q} : '0);
		m1   = {2'b00, modulus};
		m2   = {1'b0, modulus, 1'b0};
		x_m1 = x - m1;
		x_m2 = x - m2;
		if (x >= m2) begin
			r_next = x_m2[WORD_WIDTH-1:0];
		end else if (x >= m1) begin
			r_next = x_m1[WORD_WIDTH-1:0];
		end else begin
			r_next = x[WORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			sh_q  <= scan;
			a_q   <= addend;
			cnt_q <= CNT_W'(WORD_WIDTH - 1);
		end else if (busy_q) begin
			r_q   <= r_next;
			sh_q  <= sh_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done    = done_q;
	assign product = r_q;

endmodule

// ===== hw/rtl/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// mexp_dp
// datapath: configuration, base, accumulator and exponent registers
// ----------------------------------------------------------------------------
module mexp_dp import mexp_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [WORD_WIDTH-1:0]      cfg_wdata,
	input  logic [WORD_WIDTH-1:0]      base_value,
	input  mexp_cmd_t                  cmd,
	output mexp_status_t               status,
	output logic                       done,
	output logic [WORD_WIDTH-1:0]      power_result
);

	logic [WORD_WIDTH-1:0] exponent_q;
	logic [WORD_WIDTH-1:0] modulus_q;
	logic [WORD_WIDTH-1:0] base_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] exp_q;
	logic [WORD_WIDTH-1:0] result_q;
	logic                  done_q;
	mexp_op_t              op_q;

	logic [WORD_WIDTH-1:0] mul_addend;
	logic [WORD_WIDTH-1:0] mul_scan;
	logic [WORD_WIDTH-1:0] mul_product;
	logic                  mul_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= WORD_WIDTH'(EXPONENT_RESET);
			modulus_q  <= WORD_WIDTH'(MODULUS_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPONENT: exponent_q <= cfg_wdata;
				CFG_MODULUS:  modulus_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			OP_REDUCE: begin
				mul_addend = WORD_WIDTH'(1);
				mul_scan   = base_value;
			end
			OP_ACC: begin
				mul_addend = acc_q;
				mul_scan   = base_q;
			end
			OP_SQUARE: begin
				mul_addend = base_q;
				mul_scan   = base_q;
			end
			default: begin
				mul_addend = '0;
				mul_scan   = '0;
			end
		endcase
	end

	mexp_mulmod #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start_mul),
		.addend  (mul_addend),
		.scan    (mul_scan),
		.modulus (modulus_q),
		.done    (mul_done),
		.product (mul_product)
	);

	always_ff @(posedge clk) begin
		if (cmd.start_mul) begin
			op_q <= cmd.op;
		end
		if (cmd.load_item) begin
			exp_q <= exponent_q;
			acc_q <= WORD_WIDTH'(1);
		end else begin
			if (cmd.shift_exp) begin
				exp_q <= exp_q >> 1;
			end
			if (mul_done && (op_q == OP_ACC)) begin
				acc_q <= mul_product;
			end
		end
		if (mul_done && (op_q != OP_ACC)) begin
			base_q <= mul_product;
		end
		if (cmd.finish) begin
			result_q <= (modulus_q == '0) ? '0 : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_comb begin
		status.mul_done = mul_done;
		status.mod_zero = (modulus_q == '0);
		status.exp_zero = (exp_q == '0);
		status.exp_lsb  = exp_q[0];
		status.exp_last = (exp_q[WORD_WIDTH-1:1] == '0);
	end

	assign done         = done_q;
	assign power_result = result_q;

endmodule

// ===== hw/rtl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// controller: sequences reduction, multiplies and squarings per request
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  mexp_status_t status,
	output mexp_cmd_t    cmd,
	output logic         busy
);

	mexp_state_t state_q;
	mexp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = status.mod_zero ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (status.mul_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.exp_zero) begin
					state_d = ST_DONE;
				end else if (status.exp_lsb) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQUARE;
				end
			end
			ST_MUL: begin
				if (status.mul_done) begin
					state_d = status.exp_last ? ST_DONE : ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				if (status.mul_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd    = '0;
		cmd.op = OP_REDUCE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					cmd.start_mul = !status.mod_zero;
				end
			end
			ST_CHECK: begin
				if (!status.exp_zero) begin
					cmd.start_mul = 1'b1;
					cmd.op        = status.exp_lsb ? OP_ACC : OP_SQUARE;
				end
			end
			ST_MUL: begin
				if (status.mul_done && !status.exp_last) begin
					cmd.start_mul = 1'b1;
					cmd.op        = OP_SQUARE;
				end
			end
			ST_SQUARE: begin
				cmd.shift_exp = status.mul_done;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// right-to-left square-and-multiply: power_result = base_value^exponent mod modulus
// ----------------------------------------------------------------------------
// a request is taken at a clock edge with start high and busy low; base_value
// is sampled there. busy stays high until the result is presented.
// the result is on power_result for one cycle with done high; the receiver
// cannot stall, so it must take it in that cycle.
// exponent (index 0) and modulus (index 1) are written through cfg_we, cfg_index
// and cfg_wdata by the user only while the block is idle; this is not enforced.
// order of work: the base is reduced first, then every exponent bit up to the top
// set bit passes the check state, every set bit costs a multiply and every bit
// below the top set bit a square; each modular multiply runs in the shared
// one-bit-per-cycle add-and-double unit. after the last multiply the result
// passes the done state and the result register. exponent zero goes from the
// check state straight to done after the reduction, and modulus zero goes
// from idle straight to done with no multiply.
// one request at a time; the next one may start in the cycle done is high.
// reset loads exponent 65537 and modulus 3233 and returns to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [WORD_WIDTH-1:0]      base_value,
	output logic                       done,
	output logic [WORD_WIDTH-1:0]      power_result,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [WORD_WIDTH-1:0]      cfg_wdata
);

	mexp_cmd_t    cmd;
	mexp_status_t status;

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	mexp_dp #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.base_value   (base_value),
		.cmd          (cmd),
		.status       (status),
		.done         (done),
		.power_result (power_result)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result presented while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	a_mul_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		status.mul_done |-> busy)
		else $error("multiplier finished outside a request");

	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_mul |-> !status.mul_done || !busy || cmd.op == OP_SQUARE)
		else $error("multiply started during wrong phase");
`endif

endmodule

// ===== tb/sv/mexp_power_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_power_checker
// watches the request, result and register channels of the modular
// exponentiation block, predicts base_value^exponent mod modulus for each
// accepted request from its own copy of the two registers, and compares
// every result against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module mexp_power_checker import mexp_pkg::*; #(
	parameter int W = WORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [W-1:0]               base_value,
	input  logic                       done,
	input  logic [W-1:0]               power_result,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [W-1:0]               cfg_wdata,
	output int                         pending,
	output int                         fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [W-1:0] exponent_copy;
	logic [W-1:0] modulus_copy;
	logic [W-1:0] expected_powers[$];
	logic [W-1:0] oldest_power;
	int           errors;

	function automatic logic [W-1:0] predict_power(input logic [W-1:0] b,
		input logic [W-1:0] e, input logic [W-1:0] m);
		logic [2*W-1:0] acc;
		logic [2*W-1:0] run;
		logic [2*W-1:0] mm;
		logic [W-1:0]   bits;
		if (m == '0) begin
			return '0;
		end
		mm   = {{W{1'b0}}, m};
		acc  = (2*W)'(1);
		run  = {{W{1'b0}}, b} % mm;
		bits = e;
		while (bits != '0) begin
			if (bits[0]) begin
				acc = (acc * run) % mm;
			end
			bits = bits >> 1;
			run  = (run * run) % mm;
		end
		return acc[W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_copy <= W'(EXPONENT_RESET);
			modulus_copy  <= W'(MODULUS_RESET);
			expected_powers.delete();
			pending       <= 0;
			fail_count    <= 0;
		end else begin
			errors = 0;
			if (done) begin
				if (expected_powers.size() == 0) begin
					$error("power_result unexpected, expected none actual %0h", power_result);
					errors++;
				end else begin
					oldest_power = expected_powers.pop_front();
					if (power_result !== oldest_power) begin
						$error("power_result expected %0h actual %0h", oldest_power,
							power_result);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				expected_powers.push_back(predict_power(base_value, exponent_copy,
					modulus_copy));
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_EXPONENT: exponent_copy <= cfg_wdata;
					CFG_MODULUS:  modulus_copy  <= cfg_wdata;
					default: ;
				endcase
			end
			pending    <= expected_powers.size();
			fail_count <= fail_count + errors;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench of the modular exponentiation block: directed phases on the
// register extremes and the degenerate moduli, then random phases of random
// exponent and modulus settings with random bases and random request gaps;
// prediction and comparison live in the checker instantiated beside the block
// ----------------------------------------------------------------------------
module tb_top import mexp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = WORD_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 250;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [W-1:0]               base_value;
	logic                       done;
	logic [W-1:0]               power_result;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [W-1:0]               cfg_wdata;
	int                         pending;
	int                         fail_count;

	modular_exponentiation #(
		.WORD_WIDTH(W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.base_value  (base_value),
		.done        (done),
		.power_result(power_result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	mexp_power_checker #(
		.W(W)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.base_value  (base_value),
		.done        (done),
		.power_result(power_result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic write_settings(input logic [W-1:0] e, input logic [W-1:0] m);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_EXPONENT;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_index <= CFG_MODULUS;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= W'($urandom);
	endtask

	task automatic send_request(input logic [W-1:0] b, input bit steady);
		int unsigned r;
		int unsigned gap;
		start      <= 1'b1;
		base_value <= b;
		do @(posedge clk); while (busy);
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 4);
		end else begin
			gap = $urandom_range(5, 60);
		end
		if (gap != 0) begin
			start      <= 1'b0;
			base_value <= W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// lower start and wait until every request has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int           random_sent;
		int           phase_items;
		bit           steady;
		int unsigned  r;
		logic [W-1:0] e;
		logic [W-1:0] m;
		logic [W-1:0] b;
		arst_n     = 1'b0;
		start      = 1'b0;
		base_value = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_EXPONENT;
		cfg_wdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_request('0, 1'b0);
		send_request(W'(1), 1'b0);
		send_request(W'(3232), 1'b0);
		send_request(W'(3233), 1'b0);
		send_request(W'(65), 1'b1);
		send_request('1, 1'b0);
		drain();

		// exponent zero
		write_settings('0, '1);
		send_request('0, 1'b0);
		send_request(W'(5), 1'b1);
		send_request('1, 1'b0);
		drain();

		// all-ones exponent and modulus
		write_settings('1, '1);
		send_request(W'(2), 1'b0);
		send_request('1 - W'(1), 1'b0);
		send_request('1, 1'b0);
		drain();

		// modulus one
		write_settings(W'(5), W'(1));
		send_request(W'(7), 1'b0);
		send_request('0, 1'b0);
		drain();
		write_settings('0, W'(1));
		send_request(W'(9), 1'b0);
		drain();

		// modulus zero
		write_settings(W'(3), '0);
		send_request(W'(123), 1'b0);
		drain();
		write_settings('0, '0);
		send_request('1, 1'b0);
		drain();

		// smallest legal modulus, exponent one
		write_settings(W'(1), W'(2));
		send_request(W'(3), 1'b0);
		send_request('1 - W'(1), 1'b0);
		drain();

		// prime modulus near the top, fermat exponent
		write_settings(W'(32'hFFFF_FFFA), W'(32'hFFFF_FFFB));
		send_request(W'(2), 1'b0);
		drain();

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				e = W'($urandom_range(0, 3));
			end else if (r < 30) begin
				e = W'($urandom_range(4, 65537));
			end else if (r < 80) begin
				e = W'($urandom);
			end else if (r < 90) begin
				e = '1 - W'($urandom_range(0, 255));
			end else begin
				e = {1'b1, (W-1)'($urandom)};
			end
			r = $urandom_range(0, 99);
			if (r < 10) begin
				m = W'($urandom_range(0, 3));
			end else if (r < 30) begin
				m = W'($urandom_range(4, 65535));
			end else if (r < 70) begin
				m = W'($urandom);
			end else if (r < 85) begin
				m = '1 - W'($urandom_range(0, 255));
			end else begin
				m = {1'b1, (W-1)'($urandom)};
			end
			write_settings(e, m);
			phase_items = $urandom_range(8, 24);
			steady      = ($urandom_range(0, 3) == 0);
			repeat (phase_items) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					b = '0;
				end else if (r < 15) begin
					b = '1;
				end else if (r < 25 && m != '0) begin
					b = m * W'($urandom_range(0, 32'hFFFF_FFFF / m));
				end else if (r < 40 && m != '0) begin
					b = W'($urandom_range(0, m - 1));
				end else begin
					b = W'($urandom);
				end
				send_request(b, steady);
				random_sent++;
			end
			drain();
		end

		repeat (2400) @(posedge clk);
		if (fail_count == 0) begin
			$display("modular_exponentiation verification clean");
		end else begin
			$display("modular_exponentiation verification failed");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("modular_exponentiation verification failed");
		$finish;
	end

endmodule
